// ===== sv/clts_pkg.sv =====
// Shared types and constants for the character LCD tick sequencer.
// Holds the controller state, configuration and input word layouts.
// No dependencies; imported by clts_step and char_lcd_tick_sequencer_core.
`timescale 1ns / 1ps

package clts_pkg;

  typedef enum logic [1:0] {
    PH_OFF  = 2'd0,
    PH_INIT = 2'd1,
    PH_OPER = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_POWER = 3'd0,
    ST_PRE   = 3'd1,
    ST_FUNC  = 3'd2,
    ST_DISP  = 3'd3,
    ST_CLEAR = 3'd4,
    ST_ENTRY = 3'd5,
    ST_END   = 3'd6
  } init_step_t;

  typedef enum logic [1:0] {
    RQ_NONE   = 2'd0,
    RQ_WRITE  = 2'd1,
    RQ_CLEAR  = 2'd2,
    RQ_CURSOR = 2'd3
  } req_kind_t;

  // Opcodes of an input word
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_WRITE  = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_CURSOR = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_FOUR_BIT   = 3'd0;
  localparam logic [2:0] CFG_FUNC_FLAGS = 3'd1;
  localparam logic [2:0] CFG_DISP_FLAGS = 3'd2;
  localparam logic [2:0] CFG_ENTRY_FLAGS = 3'd3;
  localparam logic [2:0] CFG_TICK_MS    = 3'd4;

  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] ROW1_OFFSET  = 8'h40;
  localparam logic [7:0] POWER_ON_MS  = 8'd30;
  localparam logic [2:0] TARGET_8BIT  = 3'd2;
  localparam logic [2:0] TARGET_4BIT  = 3'd4;

  typedef struct packed {
    logic       four_bit_bus;
    logic [1:0] function_flags;
    logic [2:0] display_flags;
    logic [1:0] entry_flags;
    logic [6:0] tick_period_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] char_code;
    logic       row;
    logic [5:0] col;
  } item_t;

  typedef struct packed {
    phase_t     phase;
    init_step_t init_step;
    logic [7:0] init_counter;
    logic       enable_level;
    logic       nibble_is_low;
    logic [2:0] latch_count;
    logic       request_busy;
    req_kind_t  request_kind;
    logic [7:0] pending_char;
    logic       cursor_row;
    logic [5:0] cursor_col;
    logic       rs_level;
    logic [7:0] data_levels;
  } seq_state_t;

  localparam seq_state_t STATE_RESET = '{
    phase:         PH_OFF,
    init_step:     ST_POWER,
    init_counter:  8'd0,
    enable_level:  1'b0,
    nibble_is_low: 1'b0,
    latch_count:   3'd0,
    request_busy:  1'b0,
    request_kind:  RQ_NONE,
    pending_char:  8'd0,
    cursor_row:    1'b0,
    cursor_col:    6'd0,
    rs_level:      1'b0,
    data_levels:   8'd0
  };

endpackage

// ===== sv/clts_step.sv =====
// Next-state logic of the LCD sequencer: one input word against the current state.
// Pure combinational; depends on clts_pkg.
`timescale 1ns / 1ps

module clts_step (
  input  clts_pkg::cfg_t       cfg,
  input  clts_pkg::seq_state_t st,
  input  clts_pkg::item_t      item,
  output clts_pkg::seq_state_t st_nxt,
  output logic                 taken
);
  import clts_pkg::*;

  localparam logic [7:0] CMD_FUNC_8BIT = 8'h30;
  localparam logic [7:0] CMD_FUNC_4BIT = 8'h20;
  localparam logic [7:0] CMD_DISPLAY   = 8'h08;
  localparam logic [7:0] CMD_ENTRY     = 8'h04;
  localparam logic [7:0] PRE_NIBBLE    = 8'h02;

  // One latch half: drive data and raise enable, or drop enable
  function automatic seq_state_t latch_step(seq_state_t s_in, logic four, logic rs,
                                            logic [7:0] value);
    seq_state_t s;
    s = s_in;
    s.rs_level = rs;
    if (!s.enable_level) begin
      if (four) begin
        s.data_levels = s.nibble_is_low ? {4'h0, value[3:0]} : {4'h0, value[7:4]};
      end else begin
        s.data_levels = value;
      end
      s.enable_level = 1'b1;
    end else begin
      s.enable_level = 1'b0;
      if (four) begin
        s.nibble_is_low = !s.nibble_is_low;
      end
    end
    return s;
  endfunction

  function automatic seq_state_t init_cmd(seq_state_t s_in, logic four, logic [7:0] tgt,
                                          logic [7:0] value, init_step_t next_step);
    seq_state_t s;
    s = s_in;
    s.init_counter = s.init_counter + 8'd1;
    if (s.init_counter >= tgt) begin
      s.init_counter = 8'd0;
      s.init_step = next_step;
    end
    return latch_step(s, four, 1'b0, value);
  endfunction

  logic [2:0] tgt3;
  logic [7:0] tgt8;
  logic [7:0] func_cmd;
  logic [7:0] disp_cmd;
  logic [7:0] entry_cmd;
  logic [7:0] addr_cmd;
  seq_state_t s;

  assign tgt3 = cfg.four_bit_bus ? TARGET_4BIT : TARGET_8BIT;
  assign tgt8 = {5'd0, tgt3};
  assign func_cmd = (cfg.four_bit_bus ? CMD_FUNC_4BIT : CMD_FUNC_8BIT)
                  | {4'h0, cfg.function_flags, 2'b00};
  assign disp_cmd = CMD_DISPLAY | {5'd0, cfg.display_flags};
  assign entry_cmd = CMD_ENTRY | {6'd0, cfg.entry_flags};
  assign addr_cmd = CMD_SET_ADDR + {2'b00, st.cursor_col}
                  + (st.cursor_row ? ROW1_OFFSET : 8'h00);

  always_comb begin
    s = st;
    taken = 1'b0;
    case (item.opcode)
      OP_TICK: begin
        if (st.phase == PH_INIT) begin
          case (st.init_step)
            ST_POWER: begin
              s.init_counter = st.init_counter + {1'b0, cfg.tick_period_ms};
              if (s.init_counter >= POWER_ON_MS) begin
                s.init_counter = 8'd0;
                s.init_step = cfg.four_bit_bus ? ST_PRE : ST_FUNC;
              end
            end
            ST_PRE: begin
              s.init_counter = st.init_counter + 8'd1;
              if (s.init_counter == 8'd1) begin
                s.data_levels = PRE_NIBBLE;
                s.enable_level = 1'b1;
              end else begin
                s.enable_level = 1'b0;
                s.init_counter = 8'd0;
                s.init_step = ST_FUNC;
              end
            end
            ST_FUNC:  s = init_cmd(st, cfg.four_bit_bus, tgt8, func_cmd, ST_DISP);
            ST_DISP:  s = init_cmd(st, cfg.four_bit_bus, tgt8, disp_cmd, ST_CLEAR);
            ST_CLEAR: s = init_cmd(st, cfg.four_bit_bus, tgt8, CMD_CLEAR, ST_ENTRY);
            ST_ENTRY: s = init_cmd(st, cfg.four_bit_bus, tgt8, entry_cmd, ST_END);
            default:  s.phase = PH_OPER;
          endcase
        end else if (st.phase == PH_OPER) begin
          if (st.request_kind == RQ_WRITE) begin
            if (st.pending_char != 8'd0) begin
              s = latch_step(st, cfg.four_bit_bus, 1'b1, st.pending_char);
              s.latch_count = st.latch_count + 3'd1;
              if (s.latch_count >= tgt3) begin
                s.latch_count = 3'd0;
                s.pending_char = 8'd0;
              end
            end else begin
              s.latch_count = 3'd0;
              s.request_busy = 1'b0;
              s.request_kind = RQ_NONE;
            end
          end else if (st.request_kind inside {RQ_CLEAR, RQ_CURSOR}) begin
            if (st.latch_count >= tgt3) begin
              s.latch_count = 3'd0;
              s.request_busy = 1'b0;
              s.request_kind = RQ_NONE;
            end else begin
              s = latch_step(st, cfg.four_bit_bus, 1'b0,
                             (st.request_kind == RQ_CLEAR) ? CMD_CLEAR : addr_cmd);
              s.latch_count = st.latch_count + 3'd1;
            end
          end
        end
      end
      OP_START: begin
        if (!(st.phase inside {PH_INIT, PH_OPER})) begin
          s.phase = PH_INIT;
        end
      end
      OP_WRITE, OP_CLEAR, OP_CURSOR: begin
        if (!st.request_busy) begin
          taken = 1'b1;
          s.request_busy = 1'b1;
          if (item.opcode == OP_WRITE) begin
            s.request_kind = RQ_WRITE;
            s.pending_char = item.char_code;
          end else if (item.opcode == OP_CLEAR) begin
            s.request_kind = RQ_CLEAR;
          end else begin
            s.request_kind = RQ_CURSOR;
            s.cursor_row = item.row;
            s.cursor_col = item.col;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign st_nxt = s;

endmodule

// ===== sv/char_lcd_tick_sequencer_core.sv =====
// Character LCD tick sequencer, top level: input register, next-state logic, result register.
// An accepted word passes from the input register to the result register (out_valid high).
// Throughput: one word per cycle unless stalled; each update is one pass through clts_step.
// Reset (rst_n low, synchronous): controller off, config at defaults, both stages empty.
// Depends on clts_pkg and clts_step.
`timescale 1ns / 1ps

module char_lcd_tick_sequencer_core (
  input  logic       clk,
  input  logic       rst_n,
  // configuration write port
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_index,
  input  logic [6:0] cfg_data,
  // input words
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_opcode,
  input  logic [7:0] in_char_code,
  input  logic       in_row,
  input  logic [5:0] in_col,
  // result words
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_pin_rs,
  output logic       out_pin_rw,
  output logic       out_pin_enable,
  output logic [7:0] out_data_pins,
  output logic       out_request_taken,
  output logic       out_busy_res,
  output logic       out_ready_res
);
  import clts_pkg::*;

  cfg_t       cfg_r;
  seq_state_t st_r;
  seq_state_t st_nxt;
  item_t      item_r;
  logic       in_valid_r;
  logic       out_valid_r;
  logic       taken;
  logic       out_free;
  logic       proc_fire;
  logic       in_accept;

  logic       rs_r;
  logic       enable_r;
  logic [7:0] data_r;
  logic       taken_r;
  logic       busy_r;
  logic       ready_r;

  // The result register frees when empty or when its word leaves this cycle
  assign out_free  = !out_valid_r || !out_stall;
  // Process the held word only when there is room for its result
  assign proc_fire = in_valid_r && out_free;
  // Hold the input stage only while it is full and cannot drain
  assign in_stall  = in_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  clts_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .taken  (taken)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.four_bit_bus   <= 1'b0;
      cfg_r.function_flags <= 2'd2;
      cfg_r.display_flags  <= 3'd4;
      cfg_r.entry_flags    <= 2'd2;
      cfg_r.tick_period_ms <= 7'd2;
      st_r        <= STATE_RESET;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Configuration: indexes beyond the list are dropped
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_FOUR_BIT:    cfg_r.four_bit_bus   <= cfg_data[0];
          CFG_FUNC_FLAGS:  cfg_r.function_flags <= cfg_data[1:0];
          CFG_DISP_FLAGS:  cfg_r.display_flags  <= cfg_data[2:0];
          CFG_ENTRY_FLAGS: cfg_r.entry_flags    <= cfg_data[1:0];
          CFG_TICK_MS:     cfg_r.tick_period_ms <= cfg_data;
          default: begin
          end
        endcase
      end

      // Input stage occupancy
      if (in_accept) begin
        in_valid_r <= 1'b1;
      end else if (proc_fire) begin
        in_valid_r <= 1'b0;
      end

      // Advance controller state with each processed word
      if (proc_fire) begin
        st_r <= st_nxt;
      end

      // Result stage occupancy
      if (proc_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.opcode    <= in_opcode;
      item_r.char_code <= in_char_code;
      item_r.row       <= in_row;
      item_r.col       <= in_col;
    end
    if (proc_fire) begin
      rs_r     <= st_nxt.rs_level;
      enable_r <= st_nxt.enable_level;
      data_r   <= st_nxt.data_levels;
      taken_r  <= taken;
      busy_r   <= st_nxt.request_busy;
      ready_r  <= (st_nxt.phase == PH_OPER);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pin_rs        = rs_r;
  assign out_pin_rw        = 1'b0;
  assign out_pin_enable    = enable_r;
  assign out_data_pins     = data_r;
  assign out_request_taken = taken_r;
  assign out_busy_res      = busy_r;
  assign out_ready_res     = ready_r;

  // Once operating, the controller never leaves that phase
  a_oper_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_OPER |=> st_r.phase == PH_OPER)
    else $error("controller left operating phase");

  // A request is only taken when the controller was free
  a_taken_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && taken |-> !st_r.request_busy && st_nxt.request_busy)
    else $error("request taken while busy");

  // Latch count never passes the four-bit-bus target
  a_latch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.latch_count <= TARGET_4BIT)
    else $error("latch count out of range");

  // Enable only strobes once the controller has been started
  a_enable_started: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.enable_level |-> st_r.phase != PH_OFF)
    else $error("enable raised while off");

  // A held input word keeps its payload until it is processed
  a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !proc_fire |=> in_valid_r && $stable(item_r))
    else $error("input stage lost a word");

endmodule
